// ===== design/sqcg_pkg.sv =====
// sqcg_pkg: shared widths, register codes, corner codes, pipeline payload type
// and the sine table entry function for the sprite quad corner generator.
// no dependencies.
package sqcg_pkg;

  // default sine table resolution (quarter wave holds 2^bits + 1 entries)
  localparam int SINE_TABLE_BITS_DEF = 10;

  // field widths
  localparam int ANGLE_W  = 16;
  localparam int COORD_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int TEX_W    = 16;
  localparam int COLOR_W  = 32;

  // internal arithmetic widths
  localparam int ROM_W    = 15;  // unsigned q1.14 magnitude, up to 16384
  localparam int TRIG_W   = 16;  // signed q1.14
  localparam int SCALED_W = 33;  // signed position times scale
  localparam int HALF_W   = 32;  // unsigned size times scale
  localparam int PROD_W   = 49;  // signed half size times trig, 2^-33 units
  localparam int PAIR_W   = 50;  // sum or difference of two products
  localparam int SUM_W    = 51;  // corner offset plus centre
  localparam int FRAC_SHIFT = 29; // 2^-33 units down to q12.4
  localparam int POS_SHIFT  = 15; // centre 2^-18 units up to 2^-33 units

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_SHIFT - 1));

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 8'd1;
  localparam logic [SCALE_W-1:0]   SCALE_RESET = 16'd16384;

  // corner order of the emitted vertices
  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_TR,
    CORNER_BR,
    CORNER_BL
  } corner_e;

  // payload handed from the rotation pipe to the corner sequencer
  typedef struct packed {
    logic signed [PAIR_W-1:0] ab_sum;   // hx*cos + hy*sin
    logic signed [PAIR_W-1:0] ab_diff;  // hx*cos - hy*sin
    logic signed [PAIR_W-1:0] cd_sum;   // hx*sin + hy*cos
    logic signed [PAIR_W-1:0] cd_diff;  // hx*sin - hy*cos
    logic signed [PAIR_W-1:0] ctr_x;    // centre x plus rounding half
    logic signed [PAIR_W-1:0] ctr_y;    // centre y plus rounding half
    logic [TEX_W-1:0]         tex_left;
    logic [TEX_W-1:0]         tex_top;
    logic [TEX_W-1:0]         tex_right;
    logic [TEX_W-1:0]         tex_bottom;
    logic [COLOR_W-1:0]       color;
  } pair_t;

  // quarter-wave sine entry k in q1.14, taylor series on a q2.30 argument
  function automatic logic [ROM_W-1:0] sine_entry(input int k, input int bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (longint'(k) * 64'd1686629713) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    return ROM_W'((unsigned'(sum) + 64'd32768) >> 16);
  endfunction

endpackage

// ===== design/sqcg_if.sv =====
// sqcg interfaces: sprite request channel, vertex channel, register write channel.
// depends on sqcg_pkg for widths.

interface sqcg_sprite_if import sqcg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0]        size_w;
  logic [COORD_W-1:0]        size_h;
  logic [ANGLE_W-1:0]        spin_angle;
  logic [TEX_W-1:0]          tex_left;
  logic [TEX_W-1:0]          tex_top;
  logic [TEX_W-1:0]          tex_right;
  logic [TEX_W-1:0]          tex_bottom;
  logic [COLOR_W-1:0]        sprite_color;

  modport source (
    output valid, pos_x, pos_y, size_w, size_h, spin_angle,
           tex_left, tex_top, tex_right, tex_bottom, sprite_color,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, size_w, size_h, spin_angle,
           tex_left, tex_top, tex_right, tex_bottom, sprite_color,
    output ready
  );
endinterface

interface sqcg_vertex_if import sqcg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vert_x;
  logic signed [COORD_W-1:0] vert_y;
  logic [TEX_W-1:0]          tex_u;
  logic [TEX_W-1:0]          tex_v;
  logic [COLOR_W-1:0]        vertex_color;
  logic [1:0]                corner;
  logic                      last_corner;

  modport source (
    output valid, vert_x, vert_y, tex_u, tex_v, vertex_color, corner, last_corner,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, tex_u, tex_v, vertex_color, corner, last_corner,
    output ready
  );
endinterface

interface sqcg_cfg_if import sqcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/sqcg_sine_rom.sv =====
// sqcg_sine_rom: constant quarter-wave sine table with two registered read ports.
// depends on sqcg_pkg (sine_entry, ROM_W).
module sqcg_sine_rom import sqcg_pkg::*; #(
  parameter int TBL_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [TBL_BITS:0] addr_a_i,
  input  logic [TBL_BITS:0] addr_b_i,
  output logic [ROM_W-1:0]  data_a_o,
  output logic [ROM_W-1:0]  data_b_o
);

  localparam int ENTRIES = (1 << TBL_BITS) + 1;

  logic [ROM_W-1:0] rom_w [ENTRIES];
  logic [ROM_W-1:0] data_a_q;
  logic [ROM_W-1:0] data_b_q;

  // table contents, folded to constants at elaboration
  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    assign rom_w[k] = sine_entry(k, TBL_BITS);
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= rom_w[addr_a_i];
      data_b_q <= rom_w[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// ===== design/sqcg_rotate_pipe.sv =====
// sqcg_rotate_pipe: three register stages - scale and table read, trig products,
// corner pair sums. depends on sqcg_pkg, sqcg_if and sqcg_sine_rom.
module sqcg_rotate_pipe import sqcg_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SCALE_W-1:0] scale_x_i,
  input  logic [SCALE_W-1:0] scale_y_i,
  sqcg_sprite_if.sink        sprite_i,
  output logic               pair_valid_o,
  input  logic               pair_ready_i,
  output pair_t              pair_o
);

  localparam int IDX_W  = SINE_TABLE_BITS;
  localparam int ADDR_W = SINE_TABLE_BITS + 1;
  localparam logic [ADDR_W-1:0] QUARTER_IDX = {1'b1, IDX_W'(0)};

  // stage handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic load1;

  // table addressing
  logic [ANGLE_W-1:0] cos_angle;
  logic [IDX_W-1:0]   sin_idx, cos_idx;
  logic [ADDR_W-1:0]  sin_addr, cos_addr;
  logic [ROM_W-1:0]   sin_mag, cos_mag;

  // stage 1 registers
  logic signed [SCALED_W-1:0] px_q, py_q;
  logic [HALF_W-1:0]          hx_q, hy_q;
  logic                       sin_neg_q, cos_neg_q;
  logic [TEX_W-1:0]           s1_tl_q, s1_tt_q, s1_tr_q, s1_tb_q;
  logic [COLOR_W-1:0]         s1_color_q;

  // stage 2 registers
  logic signed [TRIG_W-1:0]   sin_v, cos_v;
  logic signed [PROD_W-1:0]   a_q, b_q, c_q, d_q, cx_q, cy_q;
  logic [TEX_W-1:0]           s2_tl_q, s2_tt_q, s2_tr_q, s2_tb_q;
  logic [COLOR_W-1:0]         s2_color_q;

  // stage 3 register
  pair_t pair_q;

  assign s3_ready = !s3_valid_q || pair_ready_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign load1    = sprite_i.valid && s1_ready;
  assign sprite_i.ready = s1_ready;

  // quadrant folding for sine and cosine addresses
  always_comb begin
    cos_angle = sprite_i.spin_angle + QUARTER_TURN;
    sin_idx   = sprite_i.spin_angle[ANGLE_W-3 -: IDX_W];
    cos_idx   = cos_angle[ANGLE_W-3 -: IDX_W];
    sin_addr  = sprite_i.spin_angle[ANGLE_W-2] ? QUARTER_IDX - {1'b0, sin_idx}
                                               : {1'b0, sin_idx};
    cos_addr  = cos_angle[ANGLE_W-2] ? QUARTER_IDX - {1'b0, cos_idx}
                                     : {1'b0, cos_idx};
  end

  sqcg_sine_rom #(
    .TBL_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk_i    (clk_i),
    .en_i     (load1),
    .addr_a_i (sin_addr),
    .addr_b_i (cos_addr),
    .data_a_o (sin_mag),
    .data_b_o (cos_mag)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= sprite_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1: scale position and size
  always_ff @(posedge clk_i) begin
    if (load1) begin
      px_q       <= sprite_i.pos_x * $signed({1'b0, scale_x_i});
      py_q       <= sprite_i.pos_y * $signed({1'b0, scale_y_i});
      hx_q       <= sprite_i.size_w * scale_x_i;
      hy_q       <= sprite_i.size_h * scale_y_i;
      sin_neg_q  <= sprite_i.spin_angle[ANGLE_W-1];
      cos_neg_q  <= cos_angle[ANGLE_W-1];
      s1_tl_q    <= sprite_i.tex_left;
      s1_tt_q    <= sprite_i.tex_top;
      s1_tr_q    <= sprite_i.tex_right;
      s1_tb_q    <= sprite_i.tex_bottom;
      s1_color_q <= sprite_i.sprite_color;
    end
  end

  // signed trig values from table magnitudes
  always_comb begin
    sin_v = sin_neg_q ? -$signed(TRIG_W'(sin_mag)) : $signed(TRIG_W'(sin_mag));
    cos_v = cos_neg_q ? -$signed(TRIG_W'(cos_mag)) : $signed(TRIG_W'(cos_mag));
  end

  // stage 2: rotate half extents, centre into 2^-33 units with rounding half
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      a_q        <= $signed({1'b0, hx_q}) * cos_v;
      b_q        <= $signed({1'b0, hy_q}) * sin_v;
      c_q        <= $signed({1'b0, hx_q}) * sin_v;
      d_q        <= $signed({1'b0, hy_q}) * cos_v;
      cx_q       <= (PROD_W'(px_q) <<< POS_SHIFT) + ROUND_HALF;
      cy_q       <= (PROD_W'(py_q) <<< POS_SHIFT) + ROUND_HALF;
      s2_tl_q    <= s1_tl_q;
      s2_tt_q    <= s1_tt_q;
      s2_tr_q    <= s1_tr_q;
      s2_tb_q    <= s1_tb_q;
      s2_color_q <= s1_color_q;
    end
  end

  // stage 3: sums and differences shared by the four corners
  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      pair_q.ab_sum     <= PAIR_W'(a_q) + PAIR_W'(b_q);
      pair_q.ab_diff    <= PAIR_W'(a_q) - PAIR_W'(b_q);
      pair_q.cd_sum     <= PAIR_W'(c_q) + PAIR_W'(d_q);
      pair_q.cd_diff    <= PAIR_W'(c_q) - PAIR_W'(d_q);
      pair_q.ctr_x      <= PAIR_W'(cx_q);
      pair_q.ctr_y      <= PAIR_W'(cy_q);
      pair_q.tex_left   <= s2_tl_q;
      pair_q.tex_top    <= s2_tt_q;
      pair_q.tex_right  <= s2_tr_q;
      pair_q.tex_bottom <= s2_tb_q;
      pair_q.color      <= s2_color_q;
    end
  end

  assign pair_valid_o = s3_valid_q;
  assign pair_o       = pair_q;

endmodule

// ===== design/sqcg_corner_seq.sv =====
// sqcg_corner_seq: walks the four corners of one sprite, adds the centre, rounds
// and saturates, and holds each vertex in the output register. depends on sqcg_pkg, sqcg_if.
module sqcg_corner_seq import sqcg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pair_valid_i,
  output logic          pair_ready_o,
  input  pair_t         pair_i,
  sqcg_vertex_if.source vert_o
);

  localparam logic signed [SUM_W-FRAC_SHIFT-1:0] SAT_MAX =
    (SUM_W-FRAC_SHIFT)'(32767);
  localparam logic signed [SUM_W-FRAC_SHIFT-1:0] SAT_MIN =
    -(SUM_W-FRAC_SHIFT)'(32768);

  logic    seq_valid_q;
  pair_t   pair_q;
  corner_e corner_q;

  logic    out_valid_q;
  logic signed [COORD_W-1:0] vx_q, vy_q;
  logic [TEX_W-1:0]          u_q, v_q;
  logic [COLOR_W-1:0]        color_q;
  logic [1:0]                corner_out_q;
  logic                      last_q;

  logic out_free, emit, last;
  logic use_diff_x, use_sum_y, negate;
  logic signed [PAIR_W-1:0] x_op, y_op;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [COORD_W-1:0] vx_d, vy_d;

  // round-down shift and clamp to q12.4
  function automatic logic signed [COORD_W-1:0] sat_q12_4(input logic signed [SUM_W-1:0] t);
    logic signed [SUM_W-FRAC_SHIFT-1:0] r;
    r = t[SUM_W-1:FRAC_SHIFT];
    if (r > SAT_MAX) begin
      return 16'sh7fff;
    end else if (r < SAT_MIN) begin
      return 16'sh8000;
    end else begin
      return COORD_W'(r);
    end
  endfunction

  assign out_free     = !out_valid_q || vert_o.ready;
  assign emit         = seq_valid_q && out_free;
  assign last         = corner_q == CORNER_BL;
  assign pair_ready_o = !seq_valid_q || (emit && last);

  // corner signs: x uses -(a-b), a+b, a-b, -(a+b); y uses -(c+d), c-d, c+d, -(c-d)
  always_comb begin
    use_diff_x = (corner_q == CORNER_TL) || (corner_q == CORNER_BR);
    use_sum_y  = use_diff_x;
    negate     = (corner_q == CORNER_TL) || (corner_q == CORNER_BL);
    x_op  = use_diff_x ? pair_q.ab_diff : pair_q.ab_sum;
    y_op  = use_sum_y  ? pair_q.cd_sum  : pair_q.cd_diff;
    sum_x = negate ? SUM_W'(pair_q.ctr_x) - SUM_W'(x_op) : SUM_W'(pair_q.ctr_x) + SUM_W'(x_op);
    sum_y = negate ? SUM_W'(pair_q.ctr_y) - SUM_W'(y_op) : SUM_W'(pair_q.ctr_y) + SUM_W'(y_op);
    vx_d  = sat_q12_4(sum_x);
    vy_d  = sat_q12_4(sum_y);
  end

  // sprite hold register and corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      corner_q    <= CORNER_TL;
    end else begin
      if (pair_ready_o) begin
        seq_valid_q <= pair_valid_i;
        corner_q    <= CORNER_TL;
      end else if (emit) begin
        corner_q    <= corner_e'(corner_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_ready_o && pair_valid_i) begin
      pair_q <= pair_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= seq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      vx_q         <= vx_d;
      vy_q         <= vy_d;
      u_q          <= negate ? pair_q.tex_left : pair_q.tex_right;
      v_q          <= corner_q[1] ? pair_q.tex_bottom : pair_q.tex_top;
      color_q      <= pair_q.color;
      corner_out_q <= corner_q;
      last_q       <= last;
    end
  end

  assign vert_o.valid        = out_valid_q;
  assign vert_o.vert_x       = vx_q;
  assign vert_o.vert_y       = vy_q;
  assign vert_o.tex_u        = u_q;
  assign vert_o.tex_v        = v_q;
  assign vert_o.vertex_color = color_q;
  assign vert_o.corner       = corner_out_q;
  assign vert_o.last_corner  = last_q;

endmodule

// ===== design/sprite_quad_corner_generator_core.sv =====
// sprite quad corner generator: one sprite request in, four vertices out.
// a request passes the rotate pipe, the corner hold register and the output register
// before its first vertex is valid; the rest follow one per cycle while the vertex
// channel is ready, which sets the sprite rate. a new request is taken every cycle
// while the pipeline has room. reset clears all valid bits and sets both scales to 1.0.
module sprite_quad_corner_generator_core import sqcg_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sqcg_sprite_if.sink   sprite_i,
  sqcg_vertex_if.source vert_o,
  sqcg_cfg_if.sink      cfg_i
);

  logic [SCALE_W-1:0] scale_x_q, scale_y_q;
  logic               pair_valid, pair_ready;
  pair_t              pair;

  // scale registers, writes to unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= SCALE_RESET;
      scale_y_q <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_SCALE_X) scale_x_q <= cfg_i.data[SCALE_W-1:0];
      if (cfg_i.index == REG_SCALE_Y) scale_y_q <= cfg_i.data[SCALE_W-1:0];
    end
  end

  sqcg_rotate_pipe #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rotate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scale_x_i    (scale_x_q),
    .scale_y_i    (scale_y_q),
    .sprite_i     (sprite_i),
    .pair_valid_o (pair_valid),
    .pair_ready_i (pair_ready),
    .pair_o       (pair)
  );

  sqcg_corner_seq u_corner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (pair_valid),
    .pair_ready_o (pair_ready),
    .pair_i       (pair),
    .vert_o       (vert_o)
  );

endmodule
